>>> sv/dlle_pkg.sv
package dlle_pkg;

    localparam int NODE_COUNT_DEF  = 64;
    localparam int LIST_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int FUNC_W = 3;
    localparam int LIST_W = 3;
    localparam int NODE_W = 6;
    localparam int OP_W   = 3;

    // func codes on the command port
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIRST  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PREV   = 3'd5;

    // classified operations handed from front to back
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIRST  = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd5;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd6;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [LIST_W-1:0] list_id;
        logic [NODE_W-1:0] node_index;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node_out;
    } rsp_t;

endpackage

>>> sv/dlle_front.sv
module dlle_front
    import dlle_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int LIST_COUNT = LIST_COUNT_DEF,
    parameter int NW         = $clog2(NODE_COUNT),
    parameter int LW         = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1
)
(
    input  logic               start,
    input  cmd_t               cmd,
    input  logic               q_full,
    output logic               busy,
    output logic               q_push,
    output logic [OP_W+LW+NW-1:0] q_wdata
);

    logic          lid_ok;
    logic          nid_ok;
    logic [OP_W-1:0] op;

    assign lid_ok = 32'(cmd.list_id) < LIST_COUNT;
    assign nid_ok = 32'(cmd.node_index) < NODE_COUNT;

    // out of range ids that a func uses and unused func codes turn into a no-op
    always_comb
    begin
        case (cmd.func)
            FUNC_CLEAR:  op = lid_ok ? OP_CLEAR : OP_NOP;
            FUNC_APPEND: op = (lid_ok && nid_ok) ? OP_APPEND : OP_NOP;
            FUNC_REMOVE: op = nid_ok ? OP_REMOVE : OP_NOP;
            FUNC_FIRST:  op = lid_ok ? OP_FIRST : OP_NOP;
            FUNC_NEXT:   op = nid_ok ? OP_NEXT : OP_NOP;
            FUNC_PREV:   op = nid_ok ? OP_PREV : OP_NOP;
            default:     op = OP_NOP;
        endcase
    end

    assign busy    = q_full;
    assign q_push  = start && !q_full;
    assign q_wdata = {op, LW'(cmd.list_id), NW'(cmd.node_index)};

endmodule

>>> sv/dlle_queue.sv
module dlle_queue
    import dlle_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full  = count_reg == (PW+1)'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/dlle_back.sv
module dlle_back
    import dlle_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int LIST_COUNT = LIST_COUNT_DEF,
    parameter int NW         = $clog2(NODE_COUNT),
    parameter int LW         = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [OP_W+LW+NW-1:0] q_rdata,
    output logic                  q_pop,
    output logic                  done,
    output rsp_t                  rsp
);

    // link = {valid, index}
    localparam int LK = NW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg;
    logic [LW-1:0]   lid_reg;
    logic [NW-1:0]   nid_reg;
    logic [LK-1:0]   old_last_reg;

    logic [OP_W-1:0] op_in;
    logic [LW-1:0]   lid_in;
    logic [NW-1:0]   nid_in;

    logic [LK-1:0] next_mem  [NODE_COUNT];
    logic [LK-1:0] prev_mem  [NODE_COUNT];
    logic [LW-1:0] own_mem   [NODE_COUNT];
    logic [LK-1:0] first_mem [LIST_COUNT];
    logic [LK-1:0] last_mem  [LIST_COUNT];

    // heads read as null until written after reset
    logic [LIST_COUNT-1:0] first_ok_reg;
    logic [LIST_COUNT-1:0] last_ok_reg;

    logic [LK-1:0] next_rd_reg, prev_rd_reg, first_rd_reg, last_rd_reg;
    logic [LW-1:0] own_rd_reg;
    logic          first_vld_rd_reg, last_vld_rd_reg;

    logic [LK-1:0] first_eff, last_eff, self_link;
    logic          own_ok;

    logic          next_we, prev_we, own_we, first_we, last_we;
    logic [NW-1:0] next_wa, prev_wa;
    logic [LW-1:0] first_wa, last_wa;
    logic [LK-1:0] next_wd, prev_wd, first_wd, last_wd;

    logic          done_next;
    rsp_t          rsp_next;
    rsp_t          rsp_reg;
    logic          done_reg;

    assign {op_in, lid_in, nid_in} = q_rdata;
    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign first_eff = first_vld_rd_reg ? first_rd_reg : '0;
    assign last_eff  = last_vld_rd_reg ? last_rd_reg : '0;
    assign self_link = {1'b1, nid_reg};
    assign own_ok    = 32'(own_rd_reg) < LIST_COUNT;

    always_comb
    begin
        state_next = state_reg;
        next_we  = 1'b0;
        prev_we  = 1'b0;
        own_we   = 1'b0;
        first_we = 1'b0;
        last_we  = 1'b0;
        next_wa  = nid_reg;
        prev_wa  = nid_reg;
        first_wa = lid_reg;
        last_wa  = lid_reg;
        next_wd  = '0;
        prev_wd  = '0;
        first_wd = '0;
        last_wd  = '0;
        done_next = 1'b0;
        rsp_next  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        first_we = 1'b1;
                        last_we  = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        own_we  = 1'b1;
                        next_we = 1'b1;
                        prev_we = 1'b1;
                        prev_wd = last_eff;
                        last_we = 1'b1;
                        last_wd = self_link;
                        if (last_eff[NW])
                        begin
                            // old tail's next link needs the write port again, so it is written in S_LINK
                            state_next = S_LINK;
                        end
                        else
                        begin
                            first_we = 1'b1;
                            first_wd = self_link;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (prev_rd_reg[NW])
                        begin
                            next_we = 1'b1;
                            next_wa = prev_rd_reg[NW-1:0];
                            next_wd = next_rd_reg;
                        end
                        else if (own_ok)
                        begin
                            first_we = 1'b1;
                            first_wa = own_rd_reg;
                            first_wd = next_rd_reg;
                        end
                        if (next_rd_reg[NW])
                        begin
                            prev_we = 1'b1;
                            prev_wa = next_rd_reg[NW-1:0];
                            prev_wd = prev_rd_reg;
                        end
                        else if (own_ok)
                        begin
                            last_we = 1'b1;
                            last_wa = own_rd_reg;
                            last_wd = prev_rd_reg;
                        end
                    end
                    OP_FIRST:
                    begin
                        rsp_next.found    = first_eff[NW];
                        rsp_next.node_out = first_eff[NW] ? NODE_W'(first_eff[NW-1:0]) : '0;
                    end
                    OP_NEXT:
                    begin
                        rsp_next.found    = next_rd_reg[NW];
                        rsp_next.node_out = next_rd_reg[NW] ? NODE_W'(next_rd_reg[NW-1:0]) : '0;
                    end
                    OP_PREV:
                    begin
                        rsp_next.found    = prev_rd_reg[NW];
                        rsp_next.node_out = prev_rd_reg[NW] ? NODE_W'(prev_rd_reg[NW-1:0]) : '0;
                    end
                    default:
                    begin
                        rsp_next = '0;
                    end
                endcase
            end
            S_LINK:
            begin
                next_we    = 1'b1;
                next_wa    = old_last_reg[NW-1:0];
                next_wd    = self_link;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            first_ok_reg <= '0;
            last_ok_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (first_we)
            begin
                first_ok_reg[first_wa] <= 1'b1;
            end
            if (last_we)
            begin
                last_ok_reg[last_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == S_EXEC)
        begin
            old_last_reg <= last_eff;
        end
        if (q_pop)
        begin
            op_reg           <= op_in;
            lid_reg          <= lid_in;
            nid_reg          <= nid_in;
            next_rd_reg      <= next_mem[nid_in];
            prev_rd_reg      <= prev_mem[nid_in];
            own_rd_reg       <= own_mem[nid_in];
            first_rd_reg     <= first_mem[lid_in];
            last_rd_reg      <= last_mem[lid_in];
            first_vld_rd_reg <= first_ok_reg[lid_in];
            last_vld_rd_reg  <= last_ok_reg[lid_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[nid_reg] <= lid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_wa] <= first_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_we)
        begin
            last_mem[last_wa] <= last_wd;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an executed transaction");

    a_link_after_append: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> $past(state_reg == S_EXEC && op_reg == OP_APPEND))
        else $error("tail link cycle not preceded by append");

    a_found_only_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.found) |->
            $past(op_reg == OP_FIRST || op_reg == OP_NEXT || op_reg == OP_PREV))
        else $error("found set on an operation that gives no answer");

    a_no_pop_while_working: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !q_pop)
        else $error("queue popped while an operation is in progress");

endmodule

>>> sv/doubly_linked_list_engine_top.sv
// Doubly linked list engine: LIST_COUNT list heads over a pool of NODE_COUNT
// nodes. A transaction is taken when start is high and busy is low; busy rises
// only while the two-entry command queue is full. Every transaction gives one
// result, shown on rsp for exactly one cycle with done high; the receiver
// cannot stall, so it must take each result as it comes. Each transaction
// passes the idle state (memory read) and then the execution state (write and
// answer); an append to a list that is not empty also passes the link state,
// since the old tail's next link shares the single write port of the next-link
// memory. done is registered from the execution state, so it rises once the
// command has left the queue and been executed. Node links and owners are not
// cleared at reset and are valid only once written by an append; list heads
// read as empty after reset.
module doubly_linked_list_engine_top
    import dlle_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int LIST_COUNT  = LIST_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int QW = OP_W + LW + NW;

    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    dlle_front #(
        .NODE_COUNT(NODE_COUNT),
        .LIST_COUNT(LIST_COUNT),
        .NW(NW),
        .LW(LW)
    ) u_front (
        .start(start),
        .cmd(cmd),
        .q_full(q_full),
        .busy(busy),
        .q_push(q_push),
        .q_wdata(q_wdata)
    );

    dlle_queue #(
        .W(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .wdata(q_wdata),
        .pop(q_pop),
        .rdata(q_rdata),
        .full(q_full),
        .empty(q_empty)
    );

    dlle_back #(
        .NODE_COUNT(NODE_COUNT),
        .LIST_COUNT(LIST_COUNT),
        .NW(NW),
        .LW(LW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_rdata(q_rdata),
        .q_pop(q_pop),
        .done(done),
        .rsp(rsp)
    );

endmodule

>>> sim/dlle_checker.sv
module dlle_checker
    import dlle_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int LIST_COUNT = LIST_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    input  logic busy,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] idx;
    } link_t;

    localparam link_t LINK_NONE = '0;

    link_t             node_next  [NODE_COUNT];
    link_t             node_prev  [NODE_COUNT];
    logic [LIST_W-1:0] node_owner [NODE_COUNT];
    link_t             head_first [LIST_COUNT];
    link_t             head_last  [LIST_COUNT];

    rsp_t rsp_expected_q[$];
    rsp_t want;
    rsp_t predicted;

    function automatic rsp_t link_answer(link_t l);
        rsp_t r;
        r.found    = l.valid;
        r.node_out = l.valid ? l.idx : '0;
        return r;
    endfunction

    // update the shadow lists for one command and give its answer
    task automatic apply_list_op(input cmd_t c, output rsp_t r);
        link_t             old_tail;
        link_t             lp;
        link_t             ln;
        logic [LIST_W-1:0] own;
        r = '0;
        case (c.func)
            FUNC_CLEAR:
            begin
                head_first[c.list_id] = LINK_NONE;
                head_last[c.list_id]  = LINK_NONE;
            end
            FUNC_APPEND:
            begin
                old_tail = head_last[c.list_id];
                node_owner[c.node_index] = c.list_id;
                node_next[c.node_index]  = LINK_NONE;
                node_prev[c.node_index]  = old_tail;
                head_last[c.list_id]     = {1'b1, c.node_index};
                // re-append of the tail itself overwrites the null next link
                if (old_tail.valid)
                    node_next[old_tail.idx] = {1'b1, c.node_index};
                else
                    head_first[c.list_id] = {1'b1, c.node_index};
            end
            FUNC_REMOVE:
            begin
                lp  = node_prev[c.node_index];
                ln  = node_next[c.node_index];
                own = node_owner[c.node_index];
                if (lp.valid)
                    node_next[lp.idx] = ln;
                else
                    head_first[own] = ln;
                if (ln.valid)
                    node_prev[ln.idx] = lp;
                else
                    head_last[own] = lp;
            end
            FUNC_FIRST: r = link_answer(head_first[c.list_id]);
            FUNC_NEXT:  r = link_answer(node_next[c.node_index]);
            FUNC_PREV:  r = link_answer(node_prev[c.node_index]);
            default:    r = '0;
        endcase
    endtask

    task automatic report_mismatch(input string what, input rsp_t got, input rsp_t exp_rsp);
        $display("mismatch at %0t: %s (got found=%0b node=%0d, want found=%0b node=%0d)",
                 $realtime, what, got.found, got.node_out, exp_rsp.found, exp_rsp.node_out);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                node_next[i]  = LINK_NONE;
                node_prev[i]  = LINK_NONE;
                node_owner[i] = '0;
            end
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_first[i] = LINK_NONE;
                head_last[i]  = LINK_NONE;
            end
            rsp_expected_q.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // results from earlier transactions are retired before this edge's command
            if (done)
            begin
                if (rsp_expected_q.size() == 0)
                    report_mismatch("result with no transaction outstanding", rsp, '0);
                else
                begin
                    want = rsp_expected_q.pop_front();
                    checked++;
                    if (rsp.found !== want.found)
                        report_mismatch("found flag", rsp, want);
                    if (rsp.node_out !== want.node_out)
                        report_mismatch("node_out", rsp, want);
                end
            end
            if (start && !busy)
            begin
                apply_list_op(cmd, predicted);
                rsp_expected_q.push_back(predicted);
            end
            pending = rsp_expected_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    import dlle_pkg::*;

    localparam int NODES      = NODE_COUNT_DEF;
    localparam int LISTS      = LIST_COUNT_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE     = 10;
    localparam int PHASE_OPS  = 280;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    localparam int PICK_FREE    = 0;
    localparam int PICK_LINKED  = 1;
    localparam int PICK_WRITTEN = 2;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    int fail_count;
    int pending;
    int checked;

    logic took = 1'b0;
    int   idle_pct = 0;
    int   cycles = 0;
    int   issued = 0;

    bit   node_written [NODES];
    bit   node_linked  [NODES];
    int   node_list    [NODES];

    doubly_linked_list_engine_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    dlle_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        took <= start && !busy;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("tb_top failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic issue_op(input logic [FUNC_W-1:0] f, input int lid, input int nid);
        cmd_t c;
        c.func       = f;
        c.list_id    = lid[LIST_W-1:0];
        c.node_index = nid[NODE_W-1:0];
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(negedge clk);
        while (!took)
            @(negedge clk);
        if (f == FUNC_APPEND)
            node_written[nid] = 1'b1;
        issued++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic int pick_node(input int mode);
        int n;
        for (int t = 0; t < 64; t++)
        begin
            n = $urandom_range(NODES - 1);
            if (mode == PICK_FREE && !node_linked[n])
                return n;
            if (mode == PICK_LINKED && node_linked[n])
                return n;
            if (mode == PICK_WRITTEN && node_written[n])
                return n;
        end
        return -1;
    endfunction

    task automatic append_node(input int lid, input int nid);
        issue_op(FUNC_APPEND, lid, nid);
        node_linked[nid] = 1'b1;
        node_list[nid]   = lid;
    endtask

    task automatic clear_list(input int lid);
        issue_op(FUNC_CLEAR, lid, $urandom_range(NODES - 1));
        for (int i = 0; i < NODES; i++)
            if (node_list[i] == lid)
                node_linked[i] = 1'b0;
    endtask

    task automatic random_op();
        int r;
        int n;
        int l;
        r = $urandom_range(99);
        l = $urandom_range(LISTS - 1);
        if (r < 32)
        begin
            n = pick_node(PICK_FREE);
            if (n >= 0) append_node(l, n);
            else issue_op(FUNC_FIRST, l, $urandom_range(NODES - 1));
        end
        else if (r < 55)
        begin
            n = pick_node(PICK_LINKED);
            if (n >= 0)
            begin
                issue_op(FUNC_REMOVE, l, n);
                node_linked[n] = 1'b0;
            end
            else issue_op(FUNC_FIRST, l, $urandom_range(NODES - 1));
        end
        else if (r < 65)
            issue_op(FUNC_FIRST, l, $urandom_range(NODES - 1));
        else if (r < 89)
        begin
            n = pick_node(PICK_WRITTEN);
            if (n < 0) issue_op(FUNC_FIRST, l, 0);
            else if (r < 77) issue_op(FUNC_NEXT, l, n);
            else issue_op(FUNC_PREV, l, n);
        end
        else if (r < 92)
            clear_list(l);
        else if (r < 94)
            issue_op(r[0] ? FUNC_SPARE_HI : FUNC_SPARE_LO, l, $urandom_range(NODES - 1));
        else if (r < 97)
        begin
            // remove regardless of membership, stale links included
            n = pick_node(PICK_WRITTEN);
            if (n >= 0)
            begin
                issue_op(FUNC_REMOVE, l, n);
                node_linked[n] = 1'b0;
            end
        end
        else
        begin
            n = pick_node(PICK_LINKED);
            if (n >= 0) append_node(l, n);
        end
    endtask

    initial
    begin
        int idle_plan[5];
        idle_plan = '{0, 68, 34, 0, 68};
        for (int i = 0; i < NODES; i++)
        begin
            node_written[i] = 1'b0;
            node_linked[i]  = 1'b0;
            node_list[i]    = -1;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty heads, extremes, head/middle/tail removal
        issue_op(FUNC_FIRST, 0, 0);
        append_node(0, 0);
        append_node(0, 63);
        append_node(7, 5);
        issue_op(FUNC_FIRST, 0, 0);
        issue_op(FUNC_NEXT, 0, 0);
        issue_op(FUNC_PREV, 0, 63);
        issue_op(FUNC_NEXT, 0, 63);
        issue_op(FUNC_PREV, 0, 0);
        issue_op(FUNC_REMOVE, 0, 0);
        issue_op(FUNC_FIRST, 0, 0);
        issue_op(FUNC_REMOVE, 0, 63);
        issue_op(FUNC_FIRST, 0, 0);
        // second remove of a node already out of its list
        issue_op(FUNC_REMOVE, 0, 63);
        // append of the node that is already the tail
        append_node(7, 5);
        issue_op(FUNC_NEXT, 7, 5);
        // clear leaves the node links in place
        clear_list(7);
        issue_op(FUNC_FIRST, 7, 0);
        issue_op(FUNC_PREV, 7, 5);
        issue_op(FUNC_SPARE_LO, 7, 63);
        issue_op(FUNC_SPARE_HI, 0, 0);
        append_node(3, 1);
        append_node(3, 2);
        append_node(3, 3);
        issue_op(FUNC_REMOVE, 3, 2);
        issue_op(FUNC_NEXT, 3, 1);
        issue_op(FUNC_PREV, 3, 3);
        drain();

        foreach (idle_plan[p])
        begin
            idle_pct = idle_plan[p];
            for (int l = 0; l < LISTS; l++)
                clear_list(l);
            for (int i = 0; i < NODES; i++)
                node_linked[i] = 1'b0;
            for (int k = 0; k < PHASE_OPS; k++)
            begin
                // hold off until the pipeline is empty once per phase
                if (k == PHASE_OPS / 2)
                    drain();
                random_op();
            end
            drain();
        end

        $display("issued %0d list commands under %0d idle settings; %0d results compared",
                 issued, 5, checked);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/dlle_pkg.sv
sv/dlle_front.sv
sv/dlle_queue.sv
sv/dlle_back.sv
sv/doubly_linked_list_engine_top.sv
sim/dlle_checker.sv
sim/tb_top.sv
